// ===== rtl/core/vertex_transform_perspective_macros.svh =====
// Assertion macros for the vertex transform block
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_MACROS_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_MACROS_SVH
`ifndef ASSERT_OFF
`define VTP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define VTP_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define VTP_ASSERT(label, clk, rst_n, prop)
`define VTP_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== rtl/core/vtp_pkg.sv =====
package vtp_pkg;
    localparam int NumRegs = 8;
    localparam logic OP_AFFINE      = 1'b0;
    localparam logic OP_PERSPECTIVE = 1'b1;

    typedef enum logic [2:0] {
        REG_R0C01 = 3'd0, REG_R0C23 = 3'd1, REG_R1C01 = 3'd2, REG_R1C23 = 3'd3,
        REG_R2C01 = 3'd4, REG_R2C23 = 3'd5, REG_R3C01 = 3'd6, REG_R3C23 = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [31:0] z_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [31:0] z_out;
        logic               w_was_zero;
        logic               saturated;
    } t_out_item;

    // Sign and magnitude of a row sum
    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } t_sm;

    // Saturate a signed magnitude to 32 bits; bit 32 of result is the clip flag
    function automatic logic [32:0] sat_signed(input logic neg, input logic [63:0] q);
        logic [32:0] res;
        if (!neg) begin
            if (q > 64'h7FFF_FFFF) res = {1'b1, 32'h7FFF_FFFF};
            else                   res = {1'b0, q[31:0]};
        end else begin
            if (q > 64'h8000_0000) res = {1'b1, 32'h8000_0000};
            else                   res = {1'b0, 32'(64'd0 - q)};
        end
        return res;
    endfunction
endpackage

// ===== rtl/core/vtp_divider.sv =====
// Pipelined restoring divider: 64-bit dividend by 32-bit divisor, one
// quotient bit per stage; the full 64-bit quotient comes out after 64 stages
module vtp_divider
    import vtp_pkg::*;
#(
    parameter int TAG_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [63:0]       i_num,
    input  logic [31:0]       i_den,
    input  logic [TAG_W-1:0]  i_tag,
    output logic              o_valid,
    output logic [63:0]       o_quot,
    output logic [TAG_W-1:0]  o_tag
);
    localparam int Steps = 64;

    // One quotient bit per stage, shift in the next dividend bit
    for (genvar s = 0; s < Steps; s++) begin : g_stage
        logic              r_v;
        logic [63:0]       r_num;
        logic [63:0]       r_q;
        logic [32:0]       r_rem;
        logic [31:0]       r_den;
        logic [TAG_W-1:0]  r_tag;
        logic              w_v;
        logic [63:0]       w_num;
        logic [63:0]       w_q;
        logic [32:0]       w_rem;
        logic [31:0]       w_den;
        logic [TAG_W-1:0]  w_tag;
        logic [33:0]       w_sh;
        logic [33:0]       w_diff;

        // Take the item from the ports or from the previous stage
        if (s == 0) begin : g_src
            assign w_v   = i_valid;
            assign w_num = i_num;
            assign w_q   = '0;
            assign w_rem = '0;
            assign w_den = i_den;
            assign w_tag = i_tag;
        end else begin : g_src
            assign w_v   = g_stage[s-1].r_v;
            assign w_num = g_stage[s-1].r_num;
            assign w_q   = g_stage[s-1].r_q;
            assign w_rem = g_stage[s-1].r_rem;
            assign w_den = g_stage[s-1].r_den;
            assign w_tag = g_stage[s-1].r_tag;
        end

        assign w_sh   = {w_rem, w_num[63]};
        assign w_diff = w_sh - {2'b00, w_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v;
            end
            if (i_en) begin
                r_num <= {w_num[62:0], 1'b0};
                r_den <= w_den;
                r_tag <= w_tag;
                if (!w_diff[33]) begin
                    r_rem <= w_diff[32:0];
                    r_q   <= {w_q[62:0], 1'b1};
                end else begin
                    r_rem <= w_sh[32:0];
                    r_q   <= {w_q[62:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = g_stage[Steps-1].r_v;
    assign o_quot  = g_stage[Steps-1].r_q;
    assign o_tag   = g_stage[Steps-1].r_tag;
endmodule

// ===== rtl/core/vtp_rowsum.sv =====
// Row dot product: multiply stage, then add stage, then sign/magnitude
module vtp_rowsum
    import vtp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [63:0]        i_c01,
    input  logic [63:0]        i_c23,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    output t_sm                o_sm
);
    logic signed [63:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [65:0] r_sum;
    logic signed [65:0] w_sum;

    // Multiply each entry by its coordinate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= $signed(i_c01[31:0])  * i_x;
            r_p1 <= $signed(i_c01[63:32]) * i_y;
            r_p2 <= $signed(i_c23[31:0])  * i_z;
            r_p3 <= 64'($signed(i_c23[63:32])) <<< FRAC_BITS;
        end
    end

    assign w_sum = 66'(r_p0) + 66'(r_p1) + 66'(r_p2) + 66'(r_p3);

    // Register the exact sum, then split sign and magnitude
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= w_sum;
        end
    end

    always_comb begin
        o_sm.neg = r_sum[65];
        o_sm.mag = r_sum[65] ? 64'(-r_sum) : r_sum[63:0];
    end
endmodule

// ===== rtl/core/vertex_transform_perspective.sv =====
// Homogeneous 4x4 vertex transform with optional perspective divide.
// Input channel: i_in_valid / o_in_stall with payload i_in (operation and
// Q16.16 point). Output channel: o_out_valid / i_out_stall with payload o_out.
// Matrix entries are written over the APB port: eight 64-bit registers at
// byte addresses 8*i, each holding two Q16.16 entries (low half column c).
// Throughput: one item per cycle while the output is not stalled. Pipeline: 68
// register stages: the multiply, sum and w-reduce stages, the 64-stage restoring
// divider (one quotient bit per stage) and the output stage.
// Affine items travel the same pipe so order is kept.
// When the receiver stalls a full output register, the whole pipe freezes and
// o_in_stall goes high; nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and sets the matrix
// to zero. Configure only while the pipe is empty.
module vertex_transform_perspective
    import vtp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
`include "vertex_transform_perspective_macros.svh"

    localparam int TagW = 1 + 1 + 1 + 3 * 32 + 1;

    logic [63:0] r_mat [NumRegs];
    logic        w_en;
    t_reg_idx    w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[5:3]);
    assign prdata = r_mat[w_idx];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumRegs; k++) r_mat[k] <= '0;
        end else if (psel && penable && pwrite) begin
            r_mat[w_idx] <= pwdata;
        end
    end

    // Whole pipe advances unless a full output is stalled
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // Stage 1-2: row sums (two register stages each)
    logic [1:0] r_v12;
    logic [1:0] r_op12;
    t_sm        w_sm [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v12 <= '0;
        end else if (w_en) begin
            r_v12 <= {r_v12[0], i_in_valid};
        end
        if (w_en) r_op12 <= {r_op12[0], i_in.operation};
    end

    for (genvar r = 0; r < 4; r++) begin : g_row
        vtp_rowsum #(.FRAC_BITS(FRAC_BITS)) u_row (
            .i_clk(i_clk), .i_en(w_en),
            .i_c01(r_mat[2*r]), .i_c23(r_mat[2*r+1]),
            .i_x(i_in.x_in), .i_y(i_in.y_in), .i_z(i_in.z_in),
            .o_sm(w_sm[r])
        );
    end

    // Stage 3: reduce w and the affine results
    logic        r_v3, r_op3, r_wz3, r_sat3, r_wneg3;
    logic [31:0] r_wmag3;
    t_sm         r_sm3 [3];
    logic [31:0] r_aff3 [3];
    logic [32:0] w_wsat;
    logic [31:0] w_wbits;
    logic        w_wz;
    logic [32:0] w_asat [3];

    always_comb begin
        w_wsat  = sat_signed(w_sm[3].neg, w_sm[3].mag >> FRAC_BITS);
        w_wz    = (w_wsat[31:0] == 32'd0);
        w_wbits = w_wz ? (32'd1 << FRAC_BITS) : w_wsat[31:0];
        for (int k = 0; k < 3; k++) w_asat[k] = sat_signed(w_sm[k].neg, w_sm[k].mag >> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v12[1];
        end
        if (w_en) begin
            r_op3   <= r_op12[1];
            r_wneg3 <= w_wbits[31];
            r_wmag3 <= w_wbits[31] ? (32'd0 - w_wbits) : w_wbits;
            if (r_op12[1] == OP_PERSPECTIVE) begin
                r_wz3  <= w_wz;
                r_sat3 <= w_wsat[32];
            end else begin
                r_wz3  <= 1'b0;
                r_sat3 <= w_asat[0][32] | w_asat[1][32] | w_asat[2][32];
            end
            for (int k = 0; k < 3; k++) begin
                r_sm3[k]  <= w_sm[k];
                r_aff3[k] <= w_asat[k][31:0];
            end
        end
    end

    // Divide stage: three dividers in lockstep, side data rides on the first tag
    logic [63:0]     w_q [3];
    logic [2:0]      w_dv;
    logic [TagW-1:0] w_tag_in, w_tag_out;
    logic [2:0]      w_nq;

    assign w_tag_in = {r_op3, r_wz3, r_sat3, r_aff3[0], r_aff3[1], r_aff3[2], r_wneg3};

    vtp_divider #(.TAG_W(TagW + 1)) u_div0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v3),
        .i_num(r_sm3[0].mag), .i_den(r_wmag3),
        .i_tag({r_sm3[0].neg, w_tag_in}),
        .o_valid(w_dv[0]), .o_quot(w_q[0]),
        .o_tag({w_nq[0], w_tag_out})
    );

    for (genvar k = 1; k < 3; k++) begin : g_div
        vtp_divider #(.TAG_W(1)) u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v3),
            .i_num(r_sm3[k].mag), .i_den(r_wmag3),
            .i_tag(r_sm3[k].neg),
            .o_valid(w_dv[k]), .o_quot(w_q[k]),
            .o_tag(w_nq[k])
        );
    end

    // Final stage: sign, saturate and choose the mode result
    t_out_item   n_out;
    logic        t_op, t_wz, t_sat, t_wneg;
    logic [31:0] t_aff [3];
    logic [32:0] w_dsat [3];

    always_comb begin
        {t_op, t_wz, t_sat, t_aff[0], t_aff[1], t_aff[2], t_wneg} = w_tag_out;
        for (int k = 0; k < 3; k++) w_dsat[k] = sat_signed(w_nq[k] != t_wneg, w_q[k]);
        n_out.w_was_zero = t_wz;
        if (t_op == OP_PERSPECTIVE) begin
            n_out.x_out     = w_dsat[0][31:0];
            n_out.y_out     = w_dsat[1][31:0];
            n_out.z_out     = w_dsat[2][31:0];
            n_out.saturated = t_sat | w_dsat[0][32] | w_dsat[1][32] | w_dsat[2][32];
        end else begin
            n_out.x_out     = t_aff[0];
            n_out.y_out     = t_aff[1];
            n_out.z_out     = t_aff[2];
            n_out.saturated = t_sat;
        end
    end

    logic r_ov;
    t_out_item r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_dv[0];
        end
        if (w_en) r_out <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    `VTP_ASSERT(a_div_lockstep, i_clk, i_rst_n, (w_dv[0] == w_dv[1]) && (w_dv[1] == w_dv[2]))
    `VTP_ASSERT(a_stall_holds, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid)
    `VTP_ASSERT(a_affine_no_wz, i_clk, i_rst_n, (o_out_valid && !t_op && w_dv[0]) |-> !t_wz)
    `VTP_ASSERT(a_stall_when_full, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall))
endmodule
